/* rtl/core/i8c2d_pkg.sv */
package i8c2d_pkg;

   // request kinds carried in req_tuser
   typedef enum logic [1:0] {
      OP_ACT     = 2'd0,
      OP_WEIGHT  = 2'd1,
      OP_BIAS    = 2'd2,
      OP_RESTART = 2'd3
   } op_type;

   // configuration register indexes
   localparam logic [2:0] REG_IN_CHANNELS  = 3'd0;
   localparam logic [2:0] REG_OUT_CHANNELS = 3'd1;
   localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd2;
   localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd3;
   localparam logic [2:0] REG_KERNEL_ROWS  = 3'd4;
   localparam logic [2:0] REG_KERNEL_COLS  = 3'd5;

   localparam int MAX_HEIGHT = 1024;
   localparam int RESULT_CAP = 16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TAPS,
      ST_DRAIN,
      ST_LOAD,
      ST_EMIT
   } state_type;

   // one tap traveling down the cell chain
   typedef struct packed {
      logic              valid;
      logic              first;
      logic signed [7:0] x;
   } tap_type;

   // sequencer commands shared by all cells
   typedef struct packed {
      logic load_sum;
      logic shift;
   } cell_ctl_type;

endpackage

/* rtl/core/i8c2d_ram.sv */
module i8c2d_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                        wdata,
   input  logic                                    re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                        rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/i8c2d_mac_cell.sv */
module i8c2d_mac_cell #(
   parameter int WDEPTH = 144,
   parameter int WAW    = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wt_we,
   input  logic [WAW-1:0]         wt_waddr,
   input  logic [7:0]             wt_wdata,
   input  logic                   bias_we,
   input  logic [31:0]            bias_wdata,
   input  i8c2d_pkg::cell_ctl_type ctl,
   input  i8c2d_pkg::tap_type     tap_in,
   input  logic [WAW-1:0]         wa_in,
   output i8c2d_pkg::tap_type     tap_out,
   output logic [WAW-1:0]         wa_out,
   input  logic [31:0]            sh_in,
   output logic [31:0]            sh_out
);

   i8c2d_pkg::tap_type tap_ff;
   logic [WAW-1:0]     wa_ff;
   logic [7:0]         w_rd;
   logic signed [15:0] p_ff;
   logic               pv_ff;
   logic               pf_ff;
   logic [31:0]        acc_ff;
   logic [31:0]        bias_ff;
   logic [31:0]        sh_ff;

   i8c2d_ram #(.WIDTH(8), .DEPTH(WDEPTH)) u_wram (
      .clock (clock),
      .we    (wt_we),
      .waddr (wt_waddr),
      .wdata (wt_wdata),
      .re    (tap_in.valid),
      .raddr (wa_in),
      .rdata (w_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff.valid <= 1'b0;
         pv_ff        <= 1'b0;
      end else begin
         tap_ff.valid <= tap_in.valid;
         pv_ff        <= tap_ff.valid;
      end
      tap_ff.first <= tap_in.first;
      tap_ff.x     <= tap_in.x;
      wa_ff        <= wa_in;
      // weight arrives the cycle after the tap, aligned with tap_ff
      p_ff  <= tap_ff.x * $signed(w_rd);
      pf_ff <= tap_ff.first;
      if (pv_ff) begin
         acc_ff <= pf_ff ? 32'(p_ff) : acc_ff + 32'(p_ff);
      end
      if (bias_we) begin
         bias_ff <= bias_wdata;
      end
      if (ctl.load_sum) begin
         sh_ff <= acc_ff + bias_ff;
      end else if (ctl.shift) begin
         sh_ff <= sh_in;
      end
   end

   assign tap_out = tap_ff;
   assign wa_out  = wa_ff;
   assign sh_out  = sh_ff;

endmodule

/* rtl/core/int8_conv2d_engine.sv */
// int8 multi-channel valid 2-D convolution engine (stride 1, no padding).
// Request channel (req_*): tuser holds the kind of request: activation,
// weight load, bias load or frame restart. Activations arrive in raster
// order with the input channel varying fastest. Result channel (rsp_*):
// one sum per output channel for each completed window, channel order,
// tlast on the final channel. The user must write the six size registers
// over csr_* only while the engine is idle; the block does not enforce it.
// csr_ready is always high. Loads, restarts and activations that close no
// window leave the engine idle. An activation that closes a window sends
// taps = input channels * kernel rows * kernel columns through the single
// line-store read port that feeds the chain of MAC cells one tap per cycle;
// after the chain drains and the sums load, results leave one per cycle
// while rsp_tready is high. The engine holds req_tready low from window
// close until the last result is taken; a stalled receiver simply holds
// the result chain. Reset clears position counters and sets size registers
// to defaults; weight, bias and line stores stay undefined until written.
module int8_conv2d_engine #(
   parameter int MAX_IN_CHANNELS  = 16,
   parameter int MAX_OUT_CHANNELS = 16,
   parameter int MAX_WIDTH        = 64,
   parameter int MAX_KERNEL       = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // activation[7:0], weight_value[15:8], bias_value[47:16],
   // filter_index[51:48], channel_index[55:52], tap_row[57:56],
   // tap_col[59:58], zero pad
   input  logic [63:0] req_tdata,
   // op[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_row[9:0], out_col[15:10], out_channel[19:16], sum[51:20], zero pad
   output logic [55:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_addr,
   input  logic [10:0] csr_wdata
);

   localparam int ICW    = MAX_IN_CHANNELS > 1 ? $clog2(MAX_IN_CHANNELS) : 1;
   localparam int OCW    = MAX_OUT_CHANNELS > 1 ? $clog2(MAX_OUT_CHANNELS) : 1;
   localparam int KW     = MAX_KERNEL > 1 ? $clog2(MAX_KERNEL) : 1;
   localparam int CW     = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1;
   localparam int PLANE  = MAX_WIDTH * MAX_IN_CHANNELS;
   localparam int LDEPTH = MAX_KERNEL * PLANE;
   localparam int LAW    = LDEPTH > 1 ? $clog2(LDEPTH) : 1;
   localparam int WDEPTH = MAX_IN_CHANNELS * MAX_KERNEL * MAX_KERNEL;
   localparam int WAW    = WDEPTH > 1 ? $clog2(WDEPTH) : 1;
   localparam int OC_CAP = MAX_OUT_CHANNELS < i8c2d_pkg::RESULT_CAP ?
                           MAX_OUT_CHANNELS : i8c2d_pkg::RESULT_CAP;
   localparam int DRN    = MAX_OUT_CHANNELS + 4;
   localparam int DW     = $clog2(DRN + 1);

   // request fields
   logic [1:0]        f_op;
   logic [7:0]        f_act;
   logic [7:0]        f_wt;
   logic [31:0]       f_bias;
   logic [3:0]        f_fi;
   logic [3:0]        f_ci;
   logic [1:0]        f_tr;
   logic [1:0]        f_tc;

   assign f_op   = req_tuser;
   assign f_act  = req_tdata[7:0];
   assign f_wt   = req_tdata[15:8];
   assign f_bias = req_tdata[47:16];
   assign f_fi   = req_tdata[51:48];
   assign f_ci   = req_tdata[55:52];
   assign f_tr   = req_tdata[57:56];
   assign f_tc   = req_tdata[59:58];

   // size registers
   logic [4:0]  in_ch_ff, out_ch_ff;
   logic [6:0]  width_ff;
   logic [10:0] height_ff;
   logic [1:0]  krows_ff, kcols_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_ch_ff  <= 5'd1;
         out_ch_ff <= 5'd1;
         width_ff  <= 7'd64;
         height_ff <= 11'd64;
         krows_ff  <= 2'd3;
         kcols_ff  <= 2'd3;
      end else if (csr_valid) begin
         if (csr_addr == i8c2d_pkg::REG_IN_CHANNELS)  in_ch_ff  <= csr_wdata[4:0];
         if (csr_addr == i8c2d_pkg::REG_OUT_CHANNELS) out_ch_ff <= csr_wdata[4:0];
         if (csr_addr == i8c2d_pkg::REG_IMAGE_WIDTH)  width_ff  <= csr_wdata[6:0];
         if (csr_addr == i8c2d_pkg::REG_IMAGE_HEIGHT) height_ff <= csr_wdata;
         if (csr_addr == i8c2d_pkg::REG_KERNEL_ROWS)  krows_ff  <= csr_wdata[1:0];
         if (csr_addr == i8c2d_pkg::REG_KERNEL_COLS)  kcols_ff  <= csr_wdata[1:0];
      end
   end

   // clamp each register to its legal range
   logic [10:0] nic, noc, wid, hgt, kr, kc;

   always_comb begin
      nic = (in_ch_ff == 5'd0) ? 11'd1 :
            (int'(in_ch_ff) > MAX_IN_CHANNELS) ? 11'(MAX_IN_CHANNELS) : 11'(in_ch_ff);
      noc = (out_ch_ff == 5'd0) ? 11'd1 :
            (int'(out_ch_ff) > OC_CAP) ? 11'(OC_CAP) : 11'(out_ch_ff);
      wid = (width_ff == 7'd0) ? 11'd1 :
            (int'(width_ff) > MAX_WIDTH) ? 11'(MAX_WIDTH) : 11'(width_ff);
      hgt = (height_ff == 11'd0) ? 11'd1 :
            (int'(height_ff) > i8c2d_pkg::MAX_HEIGHT) ? 11'(i8c2d_pkg::MAX_HEIGHT) :
            height_ff;
      kr  = (krows_ff == 2'd0) ? 11'd1 :
            (int'(krows_ff) > MAX_KERNEL) ? 11'(MAX_KERNEL) : 11'(krows_ff);
      kc  = (kcols_ff == 2'd0) ? 11'd1 :
            (int'(kcols_ff) > MAX_KERNEL) ? 11'(MAX_KERNEL) : 11'(kcols_ff);
   end

   // sequencer state
   i8c2d_pkg::state_type state_ff, state_in;
   logic [9:0]     row_ff, row_in;
   logic [CW-1:0]  col_ff, col_in;
   logic [ICW-1:0] ch_ff, ch_in;
   logic [KW-1:0]  rslot_ff, rslot_in;
   logic [9:0]     orow_ff, orow_in;
   logic [CW-1:0]  ocol_ff, ocol_in;
   logic [KW-1:0]  ob_ff, ob_in;
   logic [ICW-1:0] tic_ff, tic_in;
   logic [KW-1:0]  ta_ff, ta_in;
   logic [KW-1:0]  tb_ff, tb_in;
   logic [DW-1:0]  drn_ff, drn_in;
   logic [OCW-1:0] oc_ff, oc_in;
   logic           tap_v_ff, tap_v_in;
   logic           tap_f_ff, tap_f_in;
   logic [WAW-1:0] tap_wa_ff, tap_wa_in;
   i8c2d_pkg::cell_ctl_type ctl;

   logic        req_acc;
   logic [10:0] ch1, r1, c1;
   logic        last_ch, win;
   int          obs, slot;
   logic [LAW-1:0] lwaddr, lraddr;
   logic           lwe;
   logic [7:0]     lrdata;
   logic [WAW-1:0] wt_waddr;
   logic           wt_ok;

   assign req_tready = (state_ff == i8c2d_pkg::ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   always_comb begin
      ch1     = 11'(ch_ff) + 11'd1;
      r1      = 11'(row_ff) + 11'd1;
      c1      = 11'(col_ff) + 11'd1;
      last_ch = ch1 >= nic;
      win     = last_ch && (r1 >= kr) && (c1 >= kc);
      obs     = int'(rslot_ff) + MAX_KERNEL + 1 - int'(kr);
      if (obs >= MAX_KERNEL) obs = obs - MAX_KERNEL;
      slot    = int'(ob_ff) + int'(ta_ff);
      if (slot >= MAX_KERNEL) slot = slot - MAX_KERNEL;
      lwe     = req_acc && (f_op == i8c2d_pkg::OP_ACT);
      lwaddr  = LAW'(int'(rslot_ff) * PLANE + int'(col_ff) * MAX_IN_CHANNELS + int'(ch_ff));
      lraddr  = LAW'(slot * PLANE + (int'(ocol_ff) + int'(tb_ff)) * MAX_IN_CHANNELS +
                     int'(tic_ff));
      wt_ok   = (int'(f_ci) < MAX_IN_CHANNELS) && (int'(f_tr) < MAX_KERNEL) &&
                (int'(f_tc) < MAX_KERNEL);
      wt_waddr = WAW'((int'(f_ci) * MAX_KERNEL + int'(f_tr)) * MAX_KERNEL + int'(f_tc));
   end

   always_comb begin
      state_in  = state_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      ch_in     = ch_ff;
      rslot_in  = rslot_ff;
      orow_in   = orow_ff;
      ocol_in   = ocol_ff;
      ob_in     = ob_ff;
      tic_in    = tic_ff;
      ta_in     = ta_ff;
      tb_in     = tb_ff;
      drn_in    = drn_ff;
      oc_in     = oc_ff;
      tap_v_in  = 1'b0;
      tap_f_in  = 1'b0;
      tap_wa_in = WAW'((int'(tic_ff) * MAX_KERNEL + int'(ta_ff)) * MAX_KERNEL + int'(tb_ff));
      ctl       = '0;
      unique case (state_ff)
         i8c2d_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (f_op == i8c2d_pkg::OP_RESTART) begin
                  row_in   = '0;
                  col_in   = '0;
                  ch_in    = '0;
                  rslot_in = '0;
               end else if (f_op == i8c2d_pkg::OP_ACT) begin
                  if (win) begin
                     orow_in  = 10'(r1 - kr);
                     ocol_in  = CW'(c1 - kc);
                     ob_in    = KW'(obs);
                     tic_in   = '0;
                     ta_in    = '0;
                     tb_in    = '0;
                     state_in = i8c2d_pkg::ST_TAPS;
                  end
                  // advance position counters
                  if (last_ch) begin
                     ch_in = '0;
                     if (c1 >= wid) begin
                        col_in = '0;
                        if (r1 >= hgt) begin
                           row_in   = '0;
                           rslot_in = '0;
                        end else begin
                           row_in   = row_ff + 10'd1;
                           rslot_in = (int'(rslot_ff) == MAX_KERNEL - 1) ? '0 :
                                      rslot_ff + KW'(1);
                        end
                     end else begin
                        col_in = col_ff + CW'(1);
                     end
                  end else begin
                     ch_in = ch_ff + ICW'(1);
                  end
               end
            end
         end
         i8c2d_pkg::ST_TAPS: begin
            // issue one tap a cycle into the chain
            tap_v_in = 1'b1;
            tap_f_in = (tic_ff == '0) && (ta_ff == '0) && (tb_ff == '0);
            if (11'(tb_ff) + 11'd1 >= kc) begin
               tb_in = '0;
               if (11'(ta_ff) + 11'd1 >= kr) begin
                  ta_in = '0;
                  if (11'(tic_ff) + 11'd1 >= nic) begin
                     drn_in   = '0;
                     state_in = i8c2d_pkg::ST_DRAIN;
                  end else begin
                     tic_in = tic_ff + ICW'(1);
                  end
               end else begin
                  ta_in = ta_ff + KW'(1);
               end
            end else begin
               tb_in = tb_ff + KW'(1);
            end
         end
         i8c2d_pkg::ST_DRAIN: begin
            // wait for the last tap to clear the far end of the chain
            drn_in = drn_ff + DW'(1);
            if (int'(drn_ff) == DRN - 1) begin
               state_in = i8c2d_pkg::ST_LOAD;
            end
         end
         i8c2d_pkg::ST_LOAD: begin
            ctl.load_sum = 1'b1;
            oc_in        = '0;
            state_in     = i8c2d_pkg::ST_EMIT;
         end
         i8c2d_pkg::ST_EMIT: begin
            if (rsp_tready) begin
               ctl.shift = 1'b1;
               if (11'(oc_ff) + 11'd1 >= noc) begin
                  state_in = i8c2d_pkg::ST_IDLE;
               end else begin
                  oc_in = oc_ff + OCW'(1);
               end
            end
         end
         default: state_in = i8c2d_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= i8c2d_pkg::ST_IDLE;
         row_ff   <= '0;
         col_ff   <= '0;
         ch_ff    <= '0;
         rslot_ff <= '0;
         tap_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         ch_ff    <= ch_in;
         rslot_ff <= rslot_in;
         tap_v_ff <= tap_v_in;
      end
      orow_ff   <= orow_in;
      ocol_ff   <= ocol_in;
      ob_ff     <= ob_in;
      tic_ff    <= tic_in;
      ta_ff     <= ta_in;
      tb_ff     <= tb_in;
      drn_ff    <= drn_in;
      oc_ff     <= oc_in;
      tap_f_ff  <= tap_f_in;
      tap_wa_ff <= tap_wa_in;
   end

   // line store: last MAX_KERNEL rows, one slot per row
   i8c2d_ram #(.WIDTH(8), .DEPTH(LDEPTH)) u_line (
      .clock (clock),
      .we    (lwe),
      .waddr (lwaddr),
      .wdata (f_act),
      .re    (state_ff == i8c2d_pkg::ST_TAPS),
      .raddr (lraddr),
      .rdata (lrdata)
   );

   // chain of MAC cells, one per output channel
   i8c2d_pkg::tap_type tap_chain [MAX_OUT_CHANNELS + 1];
   logic [WAW-1:0]     wa_chain  [MAX_OUT_CHANNELS + 1];
   logic [31:0]        sh_chain  [MAX_OUT_CHANNELS + 1];

   assign tap_chain[0].valid          = tap_v_ff;
   assign tap_chain[0].first          = tap_f_ff;
   assign tap_chain[0].x              = lrdata;
   assign wa_chain[0]                 = tap_wa_ff;
   assign sh_chain[MAX_OUT_CHANNELS]  = '0;

   for (genvar i = 0; i < MAX_OUT_CHANNELS; i++) begin : g_cell
      logic cell_wt_we, cell_bias_we;

      assign cell_wt_we   = req_acc && (f_op == i8c2d_pkg::OP_WEIGHT) && wt_ok &&
                            (int'(f_fi) == i);
      assign cell_bias_we = req_acc && (f_op == i8c2d_pkg::OP_BIAS) && (int'(f_fi) == i);

      i8c2d_mac_cell #(.WDEPTH(WDEPTH), .WAW(WAW)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .wt_we      (cell_wt_we),
         .wt_waddr   (wt_waddr),
         .wt_wdata   (f_wt),
         .bias_we    (cell_bias_we),
         .bias_wdata (f_bias),
         .ctl        (ctl),
         .tap_in     (tap_chain[i]),
         .wa_in      (wa_chain[i]),
         .tap_out    (tap_chain[i+1]),
         .wa_out     (wa_chain[i+1]),
         .sh_in      (sh_chain[i+1]),
         .sh_out     (sh_chain[i])
      );
   end

   assign rsp_tvalid = (state_ff == i8c2d_pkg::ST_EMIT);
   assign rsp_tlast  = (11'(oc_ff) + 11'd1 == noc);
   assign rsp_tdata  = {4'd0, sh_chain[0], 4'(oc_ff), 6'(ocol_ff), orow_ff};

`ifndef SYNTH
   // never take a request while a result is on offer
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while result pending");

   // a taken result that is not the last is followed by another
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("result run cut short");

   // after the last result the engine is ready again
   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready && !rsp_tvalid)
      else $error("engine not idle after last result");
`endif

endmodule
